// ----- hdl/lsfe_pkg.sv -----
`default_nettype none

package lsfe_pkg;

    // Default gamma curve and table precision.
    localparam int GAMMA_X100_DEFAULT      = 220;
    localparam int GAMMA_FRAC_BITS_DEFAULT = 16;

    // Fraction bits of the fixed point used while the gamma table is built.
    localparam int WQ = 30;

    // Configuration port.
    localparam int CFG_INDEX_W = 8;
    localparam int CFG_DATA_W  = 8;
    localparam logic [CFG_INDEX_W-1:0] REG_GLOBAL_BRIGHTNESS = 8'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_RED_GAIN          = 8'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_GREEN_GAIN        = 8'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_BLUE_GAIN         = 8'd3;

    localparam logic [4:0] BRIGHTNESS_RESET = 5'd31;
    localparam logic [7:0] GAIN_RESET       = 8'd255;

    // Stream bytes.
    localparam logic [7:0] FRAME_START_BYTE = 8'h00;
    localparam logic [7:0] FRAME_END_BYTE   = 8'hFF;
    localparam logic [7:0] HEADER_BASE      = 8'hE0;

    // alpha (8 bit) times global brightness (5 bit).
    localparam int BPROD_W = 13;

    // Entries of the queue between front and back.
    localparam int QUEUE_DEPTH = 2;

    typedef struct packed {
        logic [4:0] global_brightness;
        logic [7:0] red_gain;
        logic [7:0] green_gain;
        logic [7:0] blue_gain;
    } cfg_t;

    // Classification of one pixel, made by the front part.
    typedef struct packed {
        logic               start;
        logic               fin;
        logic [BPROD_W-1:0] bprod;
    } ctl_t;

    function automatic logic [63:0] isqrt64(input logic [63:0] n_in);
        logic [63:0] n;
        logic [63:0] res;
        logic [63:0] bit_v;
        n     = n_in;
        res   = 64'd0;
        bit_v = 64'd1 << 62;
        for (int i = 0; i < 32; i++)
        begin
            if (bit_v > n)
            begin
                bit_v = bit_v >> 2;
            end
        end
        for (int i = 0; i < 32; i++)
        begin
            if (bit_v != 64'd0)
            begin
                if (n >= res + bit_v)
                begin
                    n   = n - (res + bit_v);
                    res = (res >> 1) + bit_v;
                end
                else
                begin
                    res = res >> 1;
                end
                bit_v = bit_v >> 2;
            end
        end
        return res;
    endfunction

    // log2 of v (1..255) with WQ fraction bits.
    function automatic logic [63:0] log2_q(input logic [63:0] v);
        logic [63:0] n;
        logic [63:0] y;
        logic [63:0] frac;
        n    = 64'd0;
        frac = 64'd0;
        for (int i = 0; i < 8; i++)
        begin
            if ((v >> (n + 64'd1)) != 64'd0)
            begin
                n = n + 64'd1;
            end
        end
        y = (v << WQ) >> n;
        for (int i = 1; i <= WQ; i++)
        begin
            y = (y * y) >> WQ;
            if (y >= (64'd1 << (WQ + 1)))
            begin
                y    = y >> 1;
                frac = frac | (64'd1 << (WQ - i));
            end
        end
        return (n << WQ) | frac;
    endfunction

    // One gamma table entry: (v/255)^(gamma) with frac_bits fraction bits.
    function automatic logic [63:0] gamma_entry(input int v, input int gx100,
                                                input int frac_bits);
        logic [63:0] d;
        logic [63:0] t;
        logic [63:0] ti;
        logic [63:0] m;
        logic [63:0] r;
        if (v == 0)
        begin
            return 64'd0;
        end
        d  = log2_q(64'd255) - log2_q(64'(v));
        t  = (d * 64'(gx100)) / 64'd100;
        ti = t >> WQ;
        m  = 64'd1 << WQ;
        r  = isqrt64(64'd1 << (2 * WQ - 1));
        for (int k = 1; k <= WQ; k++)
        begin
            if (t[WQ - k])
            begin
                m = (m * r) >> WQ;
            end
            r = isqrt64(r << WQ);
        end
        m = (ti >= 64'd63) ? 64'd0 : (m >> ti);
        return m >> (WQ - frac_bits);
    endfunction

endpackage

`default_nettype wire

// ----- hdl/lsfe_if.sv -----
`default_nettype none

interface lsfe_pixel_if;
    logic       valid;
    logic       ready;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic [7:0] alpha;
    logic       frame_end;

    modport source (output valid, red, green, blue, alpha, frame_end, input ready);
    modport sink   (input valid, red, green, blue, alpha, frame_end, output ready);
endinterface

interface lsfe_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       run_end;

    modport source (output valid, data_byte, run_end, input ready);
    modport sink   (input valid, data_byte, run_end, output ready);
endinterface

interface lsfe_cfg_if;
    logic       valid;
    logic       ready;
    logic [7:0] index;
    logic [7:0] data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

// ----- hdl/led_strip_frame_encoder.sv -----
`default_nettype none

// Turns RGBA pixel items into the byte stream of a serial smart LED strip: four 0x00
// bytes before the first pixel of a frame, then per pixel a brightness header and the
// gamma-corrected, gain-scaled blue, green and red bytes, and four 0xFF bytes after the
// pixel marked frame_end; run_end flags the last byte of each pixel. A front stage
// looks up the gamma table and classifies each pixel into a two-entry queue, and a
// back stage emits one byte per cycle into an output register, unless the stream holds
// it back or the queue is empty; a pixel inside a frame gives four bytes, the first
// pixel of a frame eight and the last one four more (twelve when a single pixel is a
// whole frame). Registers 0 to 3 (global brightness, red, green and blue gain) are
// written through cfg, which is always ready, and must only be changed while the
// block is idle. GAMMA_X100 sets the gamma exponent times 100 and GAMMA_FRAC_BITS the
// table precision; the table is computed during elaboration.
module led_strip_frame_encoder #(
    parameter int GAMMA_X100      = lsfe_pkg::GAMMA_X100_DEFAULT,
    parameter int GAMMA_FRAC_BITS = lsfe_pkg::GAMMA_FRAC_BITS_DEFAULT
) (
    input  wire logic   clk,
    input  wire logic   rst_n,
    lsfe_pixel_if.sink  pixel,
    lsfe_byte_if.source stream,
    lsfe_cfg_if.sink    cfg
);
    import lsfe_pkg::*;

    localparam int ENTRY_W = $bits(ctl_t) + 3 * (GAMMA_FRAC_BITS + 1);

    cfg_t               cfg_reg;
    logic               push;
    logic               pop;
    logic               q_full;
    logic               q_empty;
    logic [ENTRY_W-1:0] entry_in;
    logic [ENTRY_W-1:0] entry_out;

    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.global_brightness <= BRIGHTNESS_RESET;
            cfg_reg.red_gain          <= GAIN_RESET;
            cfg_reg.green_gain        <= GAIN_RESET;
            cfg_reg.blue_gain         <= GAIN_RESET;
        end
        else if (cfg.valid)
        begin
            case (cfg.index)
                REG_GLOBAL_BRIGHTNESS: cfg_reg.global_brightness <= cfg.data[4:0];
                REG_RED_GAIN:          cfg_reg.red_gain          <= cfg.data;
                REG_GREEN_GAIN:        cfg_reg.green_gain        <= cfg.data;
                REG_BLUE_GAIN:         cfg_reg.blue_gain         <= cfg.data;
                default:               ;
            endcase
        end
    end

    lsfe_front #(
        .GAMMA_X100      (GAMMA_X100),
        .GAMMA_FRAC_BITS (GAMMA_FRAC_BITS),
        .ENTRY_W         (ENTRY_W)
    ) u_front (
        .clk               (clk),
        .rst_n             (rst_n),
        .pixel             (pixel),
        .global_brightness (cfg_reg.global_brightness),
        .q_full            (q_full),
        .push              (push),
        .entry             (entry_in)
    );

    lsfe_queue #(
        .WIDTH (ENTRY_W),
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (push),
        .din   (entry_in),
        .full  (q_full),
        .pop   (pop),
        .dout  (entry_out),
        .empty (q_empty)
    );

    lsfe_back #(
        .GAMMA_FRAC_BITS (GAMMA_FRAC_BITS),
        .ENTRY_W         (ENTRY_W)
    ) u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .entry   (entry_out),
        .q_empty (q_empty),
        .pop     (pop),
        .cfg     (cfg_reg),
        .stream  (stream)
    );

endmodule

`default_nettype wire

// ----- hdl/lsfe_queue.sv -----
`default_nettype none

module lsfe_queue #(
    parameter int WIDTH = 8,
    parameter int DEPTH = lsfe_pkg::QUEUE_DEPTH
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             push,
    input  wire logic [WIDTH-1:0] din,
    output logic                  full,
    input  wire logic             pop,
    output logic [WIDTH-1:0]      dout,
    output logic                  empty
);
    import lsfe_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;

    assign full  = (count_reg == CNT_W'(DEPTH));
    assign empty = (count_reg == '0);
    assign dout  = mem_reg[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= din;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> (!full || pop))
        else $error("queue written while full");

    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> !empty)
        else $error("queue read while empty");

endmodule

`default_nettype wire

// ----- hdl/lsfe_front.sv -----
`default_nettype none

module lsfe_front #(
    parameter int GAMMA_X100      = lsfe_pkg::GAMMA_X100_DEFAULT,
    parameter int GAMMA_FRAC_BITS = lsfe_pkg::GAMMA_FRAC_BITS_DEFAULT,
    parameter int ENTRY_W         = $bits(lsfe_pkg::ctl_t) + 3 * (GAMMA_FRAC_BITS + 1)
) (
    input  wire logic          clk,
    input  wire logic          rst_n,
    lsfe_pixel_if.sink         pixel,
    input  wire logic [4:0]    global_brightness,
    input  wire logic          q_full,
    output logic               push,
    output logic [ENTRY_W-1:0] entry
);
    import lsfe_pkg::*;

    localparam int RW = GAMMA_FRAC_BITS + 1;

    logic [RW-1:0]      rom [256];
    logic               frame_open_reg;
    ctl_t               ctl;
    logic [2:0][RW-1:0] gam;

    // The gamma table is folded to constants at elaboration.
    for (genvar v = 0; v < 256; v++)
    begin : g_rom
        assign rom[v] = RW'(gamma_entry(v, GAMMA_X100, GAMMA_FRAC_BITS));
    end

    assign pixel.ready = !q_full;
    assign push        = pixel.valid && !q_full;

    always_comb
    begin
        ctl.start = !frame_open_reg;
        ctl.fin   = pixel.frame_end;
        ctl.bprod = BPROD_W'(pixel.alpha) * BPROD_W'(global_brightness);
        // Byte order on the strip: blue, green, red.
        gam[0]    = rom[pixel.blue];
        gam[1]    = rom[pixel.green];
        gam[2]    = rom[pixel.red];
    end

    assign entry = {ctl, gam};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_open_reg <= 1'b0;
        end
        else if (push)
        begin
            frame_open_reg <= !pixel.frame_end;
        end
    end

endmodule

`default_nettype wire

// ----- hdl/lsfe_back.sv -----
`default_nettype none

module lsfe_back #(
    parameter int GAMMA_FRAC_BITS = lsfe_pkg::GAMMA_FRAC_BITS_DEFAULT,
    parameter int ENTRY_W         = $bits(lsfe_pkg::ctl_t) + 3 * (GAMMA_FRAC_BITS + 1)
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic [ENTRY_W-1:0] entry,
    input  wire logic               q_empty,
    output logic                    pop,
    input  wire lsfe_pkg::cfg_t     cfg,
    lsfe_byte_if.source             stream
);
    import lsfe_pkg::*;

    localparam int RW    = GAMMA_FRAC_BITS + 1;
    localparam int CTL_W = $bits(ctl_t);
    localparam int PW    = RW + 8;

    typedef enum logic [1:0] {
        SEG_START,
        SEG_PIXEL,
        SEG_END
    } seg_t;

    seg_t               seg_reg, seg_next, cur_seg;
    logic [1:0]         cnt_reg, cnt_next;
    logic               fresh_reg, fresh_next;
    logic               out_valid_reg, out_valid_next;
    logic [7:0]         data_reg, data_next;
    logic               run_end_reg, run_end_next;

    ctl_t               ctl;
    logic [2:0][RW-1:0] gam;
    logic [RW-1:0]      gam_sel;
    logic [7:0]         gain_sel;
    logic [PW-1:0]      prod;
    logic [BPROD_W:0]   quot;
    logic [7:0]         header;
    logic [7:0]         byte_val;
    logic               adv;
    logic               fire;
    logic               last;

    assign ctl = ctl_t'(entry[ENTRY_W-1 -: CTL_W]);
    assign gam = entry[3*RW-1:0];

    always_comb
    begin
        // A new entry opens with the start frame only if it begins a frame.
        cur_seg = fresh_reg ? (ctl.start ? SEG_START : SEG_PIXEL) : seg_reg;
        adv     = !out_valid_reg || stream.ready;
        fire    = adv && !q_empty;

        case (cnt_reg)
            2'd2:
            begin
                gam_sel  = gam[1];
                gain_sel = cfg.green_gain;
            end
            2'd3:
            begin
                gam_sel  = gam[2];
                gain_sel = cfg.red_gain;
            end
            default:
            begin
                gam_sel  = gam[0];
                gain_sel = cfg.blue_gain;
            end
        endcase
        prod = PW'(gam_sel) * PW'(gain_sel);

        // Division by 255, exact for every product of alpha and brightness.
        quot   = ((BPROD_W + 1)'(ctl.bprod) + 1'b1 + (BPROD_W + 1)'(ctl.bprod >> 8)) >> 8;
        header = HEADER_BASE | {3'b000, quot[4:0]};

        case (cur_seg)
            SEG_START: byte_val = FRAME_START_BYTE;
            SEG_PIXEL: byte_val = (cnt_reg == 2'd0) ? header : prod[GAMMA_FRAC_BITS +: 8];
            SEG_END:   byte_val = FRAME_END_BYTE;
            default:   byte_val = FRAME_START_BYTE;
        endcase

        last = (cnt_reg == 2'd3)
            && ((cur_seg == SEG_END) || ((cur_seg == SEG_PIXEL) && !ctl.fin));
        pop  = fire && last;

        seg_next       = seg_reg;
        cnt_next       = cnt_reg;
        fresh_next     = fresh_reg;
        out_valid_next = out_valid_reg;
        data_next      = data_reg;
        run_end_next   = run_end_reg;

        if (fire)
        begin
            cnt_next       = cnt_reg + 2'd1;
            fresh_next     = last;
            out_valid_next = 1'b1;
            data_next      = byte_val;
            run_end_next   = last;
            seg_next       = cur_seg;
            if (cnt_reg == 2'd3)
            begin
                case (cur_seg)
                    SEG_START: seg_next = SEG_PIXEL;
                    SEG_PIXEL: seg_next = SEG_END;
                    default:   seg_next = SEG_START;
                endcase
            end
        end
        else if (stream.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seg_reg       <= SEG_START;
            cnt_reg       <= 2'd0;
            fresh_reg     <= 1'b1;
            out_valid_reg <= 1'b0;
            data_reg      <= FRAME_START_BYTE;
            run_end_reg   <= 1'b0;
        end
        else
        begin
            seg_reg       <= seg_next;
            cnt_reg       <= cnt_next;
            fresh_reg     <= fresh_next;
            out_valid_reg <= out_valid_next;
            data_reg      <= data_next;
            run_end_reg   <= run_end_next;
        end
    end

    assign stream.valid     = out_valid_reg;
    assign stream.data_byte = data_reg;
    assign stream.run_end   = run_end_reg;

    a_fresh_at_zero: assert property (@(posedge clk) disable iff (!rst_n)
        fresh_reg |-> (cnt_reg == 2'd0))
        else $error("entry starts at a nonzero byte count");

    a_mid_entry_held: assert property (@(posedge clk) disable iff (!rst_n)
        !fresh_reg |-> !q_empty)
        else $error("entry left the queue before its last byte");

    a_pop_marks_end: assert property (@(posedge clk) disable iff (!rst_n)
        pop |=> (stream.valid && stream.run_end))
        else $error("entry retired without a closing byte");

    a_end_frame_only_on_fin: assert property (@(posedge clk) disable iff (!rst_n)
        (fire && (cur_seg == SEG_END)) |-> ctl.fin)
        else $error("end frame sent for a pixel that does not close the frame");

endmodule

`default_nettype wire

// ----- tb/tb.sv -----
`default_nettype none

module tb;
    import lsfe_pkg::*;

    localparam int GAMMA_PCT  = 220;
    localparam int GAMMA_FRAC = 16;
    // Fraction bits used while the gamma curve is computed.
    localparam int FIX = 30;
    // Indexes from here up are not registers and must be ignored.
    localparam int REG_COUNT = 4;
    localparam int MAX_REPORTS = 50;

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic [7:0] alpha;
        logic       frame_end;
    } pixel_t;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       run_end;
    } strip_byte_t;

    logic clk = 1'b0;
    logic rst_n;

    lsfe_pixel_if pix ();
    lsfe_byte_if  strm ();
    lsfe_cfg_if   cfg_if ();

    led_strip_frame_encoder #(
        .GAMMA_X100      (GAMMA_PCT),
        .GAMMA_FRAC_BITS (GAMMA_FRAC)
    ) dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .pixel  (pix),
        .stream (strm),
        .cfg    (cfg_if)
    );

    always #5 clk = ~clk;

    pixel_t      pending_px [$];
    strip_byte_t expected_bytes [$];
    pixel_t      in_flight;
    logic [GAMMA_FRAC:0] gamma_lut [256];
    cfg_t        strip_cfg = '{global_brightness: BRIGHTNESS_RESET, red_gain: GAIN_RESET,
                               green_gain: GAIN_RESET, blue_gain: GAIN_RESET};
    logic        frame_open = 1'b0;
    logic        quiet = 1'b0;
    int          error_count = 0;
    int          src_gap;
    int          sink_gap;

    function automatic logic [63:0] sqrt_floor(input logic [63:0] x);
        logic [63:0] rem;
        logic [63:0] root;
        logic [63:0] probe;
        rem   = x;
        root  = 64'd0;
        probe = 64'd1 << 62;
        while (probe > rem)
        begin
            probe = probe >> 2;
        end
        while (probe != 64'd0)
        begin
            if (rem >= root + probe)
            begin
                rem  = rem - (root + probe);
                root = (root >> 1) + probe;
            end
            else
            begin
                root = root >> 1;
            end
            probe = probe >> 2;
        end
        return root;
    endfunction

    // Base-2 logarithm with FIX fraction bits; each fraction bit comes from
    // squaring the mantissa and checking whether it reached two.
    function automatic logic [63:0] log2_fix(input logic [7:0] v);
        int          msb;
        logic [63:0] mant;
        logic [63:0] frac;
        msb  = 0;
        frac = 64'd0;
        for (int i = 0; i < 8; i++)
        begin
            if (v[i])
            begin
                msb = i;
            end
        end
        mant = (64'(v) << FIX) >> msb;
        for (int i = 1; i <= FIX; i++)
        begin
            mant = (mant * mant) >> FIX;
            if (mant >= (64'd1 << (FIX + 1)))
            begin
                mant = mant >> 1;
                frac = frac | (64'd1 << (FIX - i));
            end
        end
        return (64'(msb) << FIX) | frac;
    endfunction

    // (v/255)^gamma, computed as 2^-t with t = gamma * log2(255/v).
    function automatic logic [GAMMA_FRAC:0] gamma_value(input int v);
        logic [63:0] expo;
        logic [63:0] whole;
        logic [63:0] scale;
        logic [63:0] root;
        if (v == 0)
        begin
            return '0;
        end
        expo  = ((log2_fix(8'd255) - log2_fix(8'(v))) * 64'(GAMMA_PCT)) / 64'd100;
        whole = expo >> FIX;
        scale = 64'd1 << FIX;
        root  = sqrt_floor(64'd1 << (2 * FIX - 1));
        for (int k = 1; k <= FIX; k++)
        begin
            if (expo[FIX - k])
            begin
                scale = (scale * root) >> FIX;
            end
            root = sqrt_floor(root << FIX);
        end
        scale = (whole >= 64'd63) ? 64'd0 : (scale >> whole);
        return (GAMMA_FRAC + 1)'(scale >> (FIX - GAMMA_FRAC));
    endfunction

    function automatic logic [7:0] scaled_colour(input logic [7:0] c, input logic [7:0] gain);
        logic [31:0] prod;
        prod = 32'(gamma_lut[c]) * 32'(gain);
        return prod[GAMMA_FRAC +: 8];
    endfunction

    function automatic void encode_pixel(input pixel_t px);
        logic [7:0]  seq [12];
        logic [12:0] bprod;
        logic [12:0] bright;
        int          n;
        n = 0;
        if (!frame_open)
        begin
            for (int i = 0; i < 4; i++)
            begin
                seq[n] = FRAME_START_BYTE;
                n++;
            end
            frame_open = 1'b1;
        end
        bprod  = 13'(px.alpha) * 13'(strip_cfg.global_brightness);
        bright = bprod / 13'd255;
        seq[n]     = HEADER_BASE | {3'b000, bright[4:0]};
        seq[n + 1] = scaled_colour(px.blue, strip_cfg.blue_gain);
        seq[n + 2] = scaled_colour(px.green, strip_cfg.green_gain);
        seq[n + 3] = scaled_colour(px.red, strip_cfg.red_gain);
        n = n + 4;
        if (px.frame_end)
        begin
            for (int i = 0; i < 4; i++)
            begin
                seq[n] = FRAME_END_BYTE;
                n++;
            end
            frame_open = 1'b0;
        end
        for (int k = 0; k < n; k++)
        begin
            expected_bytes.push_back('{data_byte: seq[k], run_end: (k == n - 1)});
        end
    endfunction

    task automatic report_mismatch(input string what, input int got, input int want);
        if (error_count < MAX_REPORTS)
        begin
            $display("tb: mismatch on %s: got %0h, expected %0h, at %0t", what, got, want, $time);
        end
        error_count++;
    endtask

    // Pixel driver: valid stays up until the item is taken.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pix.valid     <= 1'b0;
            pix.red       <= 8'd0;
            pix.green     <= 8'd0;
            pix.blue      <= 8'd0;
            pix.alpha     <= 8'd0;
            pix.frame_end <= 1'b0;
            src_gap = 0;
        end
        else
        begin
            if (pix.valid && pix.ready)
            begin
                encode_pixel(in_flight);
            end
            if (!pix.valid || pix.ready)
            begin
                if (src_gap > 0)
                begin
                    src_gap--;
                    pix.valid <= 1'b0;
                end
                else if (!quiet && $urandom_range(0, 7) == 0)
                begin
                    src_gap = $urandom_range(1, 19) - 1;
                    pix.valid <= 1'b0;
                end
                else if (pending_px.size() != 0)
                begin
                    in_flight = pending_px.pop_front();
                    pix.valid     <= 1'b1;
                    pix.red       <= in_flight.red;
                    pix.green     <= in_flight.green;
                    pix.blue      <= in_flight.blue;
                    pix.alpha     <= in_flight.alpha;
                    pix.frame_end <= in_flight.frame_end;
                end
                else
                begin
                    pix.valid <= 1'b0;
                end
            end
        end
    end

    // Byte monitor with random back-pressure.
    always @(posedge clk or negedge rst_n)
    begin
        strip_byte_t want;
        if (!rst_n)
        begin
            strm.ready <= 1'b0;
            sink_gap = 0;
        end
        else
        begin
            if (strm.valid && strm.ready)
            begin
                if (expected_bytes.size() == 0)
                begin
                    report_mismatch("unexpected byte", int'(strm.data_byte), 0);
                end
                else
                begin
                    want = expected_bytes.pop_front();
                    if (strm.data_byte !== want.data_byte)
                    begin
                        report_mismatch("data_byte", int'(strm.data_byte), int'(want.data_byte));
                    end
                    if (strm.run_end !== want.run_end)
                    begin
                        report_mismatch("run_end", int'(strm.run_end), int'(want.run_end));
                    end
                end
            end
            if (sink_gap > 0)
            begin
                sink_gap--;
                strm.ready <= 1'b0;
            end
            else if (!quiet && $urandom_range(0, 9) == 0)
            begin
                sink_gap = $urandom_range(1, 19) - 1;
                strm.ready <= 1'b0;
            end
            else
            begin
                strm.ready <= 1'b1;
            end
        end
    end

    // Register shadow follows every accepted write.
    always @(posedge clk)
    begin
        if (rst_n && cfg_if.valid && cfg_if.ready)
        begin
            case (cfg_if.index)
                REG_GLOBAL_BRIGHTNESS: strip_cfg.global_brightness = cfg_if.data[4:0];
                REG_RED_GAIN:          strip_cfg.red_gain = cfg_if.data;
                REG_GREEN_GAIN:        strip_cfg.green_gain = cfg_if.data;
                REG_BLUE_GAIN:         strip_cfg.blue_gain = cfg_if.data;
                default:               ;
            endcase
        end
    end

    task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] value);
        cfg_if.valid <= 1'b1;
        cfg_if.index <= idx;
        cfg_if.data  <= value;
        do
            @(posedge clk);
        while (!cfg_if.ready);
        cfg_if.valid <= 1'b0;
        @(posedge clk);
    endtask

    // Brightness is written with random bits above its five, which must be dropped.
    task automatic write_settings(input logic [4:0] bright, input logic [7:0] r,
                                  input logic [7:0] g, input logic [7:0] b);
        write_reg(REG_GLOBAL_BRIGHTNESS, {3'($urandom), bright});
        if ($urandom_range(0, 1) == 0)
        begin
            write_reg(CFG_INDEX_W'($urandom_range(255, REG_COUNT)), 8'($urandom));
        end
        write_reg(REG_RED_GAIN, r);
        write_reg(REG_GREEN_GAIN, g);
        write_reg(REG_BLUE_GAIN, b);
    endtask

    task automatic drain();
        do
            @(posedge clk);
        while (pending_px.size() != 0 || pix.valid || expected_bytes.size() != 0);
    endtask

    task automatic add_pixel(input logic [7:0] r, input logic [7:0] g, input logic [7:0] b,
                             input logic [7:0] a, input logic fe);
        pending_px.push_back('{red: r, green: g, blue: b, alpha: a, frame_end: fe});
    endtask

    function automatic logic [7:0] rand_channel();
        case ($urandom_range(0, 9))
            0:       return 8'd0;
            1:       return 8'd255;
            default: return 8'($urandom);
        endcase
    endfunction

    // Frames of one to six pixels; the last frame may stay open into the next phase.
    task automatic add_frames(input int count);
        int left;
        left = 0;
        for (int i = 0; i < count; i++)
        begin
            if (left == 0)
            begin
                left = $urandom_range(1, 6);
            end
            left--;
            add_pixel(rand_channel(), rand_channel(), rand_channel(), rand_channel(),
                      left == 0);
        end
    endtask

    initial
    begin
        rst_n        <= 1'b0;
        cfg_if.valid <= 1'b0;
        cfg_if.index <= '0;
        cfg_if.data  <= '0;
        for (int v = 0; v < 256; v++)
        begin
            gamma_lut[v] = gamma_value(v);
        end
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset settings: one-pixel frames, then a frame of extreme values and a two-pixel frame.
        add_pixel(8'd0, 8'd0, 8'd0, 8'd0, 1'b1);
        add_pixel(8'd255, 8'd255, 8'd255, 8'd255, 1'b1);
        add_pixel(8'd255, 8'd0, 8'd0, 8'd255, 1'b0);
        add_pixel(8'd0, 8'd255, 8'd0, 8'd128, 1'b0);
        add_pixel(8'd0, 8'd0, 8'd255, 8'd1, 1'b0);
        add_pixel(8'h55, 8'hAA, 8'h55, 8'hAA, 1'b0);
        add_pixel(8'hAA, 8'h55, 8'hAA, 8'h55, 1'b0);
        add_pixel(8'd1, 8'd2, 8'd254, 8'd254, 1'b1);
        add_pixel(8'd128, 8'd64, 8'd32, 8'd16, 1'b0);
        add_pixel(8'd3, 8'd7, 8'd15, 8'd31, 1'b1);
        drain();

        // Oversized brightness value, writes to unused indexes, zero and odd gains.
        write_reg(REG_GLOBAL_BRIGHTNESS, 8'hFF);
        write_reg(CFG_INDEX_W'(REG_COUNT), 8'h00);
        write_reg(8'd255, 8'h00);
        write_reg(REG_RED_GAIN, 8'd0);
        write_reg(REG_GREEN_GAIN, 8'd128);
        write_reg(REG_BLUE_GAIN, 8'd1);
        add_pixel(8'd255, 8'd255, 8'd255, 8'd255, 1'b0);
        add_pixel(8'd200, 8'd100, 8'd50, 8'd0, 1'b0);
        add_pixel(8'd1, 8'd1, 8'd1, 8'd254, 1'b1);
        add_pixel(8'd255, 8'd255, 8'd255, 8'd255, 1'b1);
        drain();

        for (int phase = 0; phase < 8; phase++)
        begin
            if (phase == 0)
            begin
                write_settings(5'd0, 8'd0, 8'd0, 8'd0);
            end
            else if (phase == 1 || phase == 7)
            begin
                write_settings(BRIGHTNESS_RESET, GAIN_RESET, GAIN_RESET, GAIN_RESET);
            end
            else
            begin
                write_settings(5'($urandom), 8'($urandom), 8'($urandom), 8'($urandom));
            end
            quiet = (phase == 7);
            add_frames(30);
            drain();
        end

        repeat (16) @(posedge clk);
        if (error_count == 0)
        begin
            $display("tb: done, clean");
        end
        else
        begin
            $display("tb: done, errors");
        end
        $finish;
    end

    initial
    begin
        #5000000;
        $display("tb: done, errors");
        $finish;
    end

endmodule

`default_nettype wire

// ----- sim.f -----
hdl/lsfe_pkg.sv
hdl/lsfe_if.sv
hdl/lsfe_queue.sv
hdl/lsfe_front.sv
hdl/lsfe_back.sv
hdl/led_strip_frame_encoder.sv
tb/tb.sv
